/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
// Depends on nothing; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define BHA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be true outside reset.
`define BHA_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

/* rtl/bha_pkg.sv */
// Shared constants and controller/datapath interface types for the buddy allocator.
// Depends on nothing.
package bha_pkg;

   localparam int UNITS      = 512;
   localparam int UNIT_BITS  = 9;
   localparam int MIN_BLOCK  = 32;
   localparam int MIN_SHIFT  = 5;
   localparam int MAX_BLOCK  = 16384;
   localparam int ENTRY_W    = 16;
   localparam int LG_W       = 4;
   localparam logic [31:0] HEAP_BASE_RST = 32'h2000_1000;
   localparam logic        CMD_ALLOC = 1'b0;
   localparam logic        CMD_FREE  = 1'b1;
   localparam logic        REG_HEAP_BASE = 1'b0;

   typedef struct packed {
      logic load;
      logic clr_wr;
      logic init_scan;
      logic init_free;
      logic scan_rd;
      logic scan_hit_wr;
      logic scan_next;
      logic unw_rd;
      logic unw_wr;
      logic unw_next;
      logic fr_rd;
      logic fr_head_wr;
      logic bud_rd;
      logic mrg_wr_hi;
      logic mrg_wr_lo;
      logic rsp_alloc;
      logic rsp_free;
      logic rsp_fail;
   } dp_cmd_type;

   typedef struct packed {
      logic is_free;
      logic size_bad;
      logic addr_bad;
      logic hit;
      logic scan_last;
      logic unw_done;
      logic go_left;
      logic rd_free;
      logic head_zero;
      logic bud_out;
      logic bud_match;
      logic clr_done;
   } dp_stat_type;

endpackage

/* rtl/buddy_heap_allocator_core.sv */
// Buddy heap allocator: 512 units of 32 bytes, table in one RAM, walked one entry at a time.
// Allocate: check, then read and evaluate per probed block (up to 512), then unwind by level.
// Free: head read, buddy read and compare per merge, at most 9 merges. One request at a time.
// All table accesses go through the one table RAM; results wait in a register for rsp_ready.
// Synchronous active-high reset: heap_base reloads, then a clear pass writes every table entry
// with req_ready low (CSR writes still taken).
module buddy_heap_allocator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [15:0] req_size,
   input  logic [31:0] req_block_addr,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [31:0] rsp_result_addr,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]          base_ff;
   bha_pkg::dp_cmd_type  cmd;
   bha_pkg::dp_stat_type stat;
   logic                 reg_sel;

   assign reg_sel    = csr_paddr[2] == bha_pkg::REG_HEAP_BASE;
   assign csr_pready = 1'b1;
   assign csr_prdata = reg_sel ? base_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= bha_pkg::HEAP_BASE_RST;
      end else if (csr_psel && csr_penable && csr_pwrite && reg_sel) begin
         base_ff <= csr_pwdata;
      end
   end

   bha_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .stat      (stat)
   );

   bha_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .heap_base       (base_ff),
      .req_cmd         (req_cmd),
      .req_size        (req_size),
      .req_block_addr  (req_block_addr),
      .rsp_ok          (rsp_ok),
      .rsp_result_addr (rsp_result_addr)
   );

endmodule

/* rtl/bha_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module bha_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/bha_dp.sv */
// Datapath: request registers, scan and merge pointers, control table RAM, result registers.
// Depends on bha_pkg and bha_ram.
module bha_dp (
   input  logic                 clock,
   input  logic                 reset,
   input  bha_pkg::dp_cmd_type  cmd,
   output bha_pkg::dp_stat_type stat,
   input  logic [31:0]          heap_base,
   input  logic                 req_cmd,
   input  logic [15:0]          req_size,
   input  logic [31:0]          req_block_addr,
   output logic                 rsp_ok,
   output logic [31:0]          rsp_result_addr
);

   localparam int UB = bha_pkg::UNIT_BITS;
   localparam int EW = bha_pkg::ENTRY_W;
   localparam int LW = bha_pkg::LG_W;

   logic          cmd_ff;
   logic [15:0]   size_ff;
   logic [31:0]   addr_ff;
   logic [LW-1:0] lg_ff, lg_in;
   logic [LW-1:0] lgm_ff, lgm_in;
   logic [UB:0]   pos_ff, pos_in;
   logic [UB-1:0] idx_ff, idx_in;
   logic [EW-1:0] c_ff, c_in;
   logic [UB-1:0] bud_ff;
   logic [UB-1:0] clr_ff;
   logic          ok_ff;
   logic [31:0]   res_ff;

   logic          wr_en, rd_en;
   logic [UB-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rdata;

   logic [LW-1:0] lg_req;
   logic [UB:0]   n_units, m_units, pos_next, pos_plus_m;
   logic [EW-1:0] need, m_bytes;
   logic [31:0]   off;
   logic [UB+1:0] units;
   logic [UB+2:0] bud_sum;
   logic          bud_left;
   logic [UB-1:0] hi_idx, lo_idx;

   // smallest level whose block holds the request
   always_comb begin
      lg_req = LW'(UB);
      for (int i = UB; i >= 0; i--) begin
         if ({1'b0, req_size} <= 17'(bha_pkg::MIN_BLOCK << i)) begin
            lg_req = LW'(i);
         end
      end
   end

   assign n_units    = (UB+1)'(1) << lg_ff;
   assign m_units    = (UB+1)'(1) << lgm_ff;
   assign pos_next   = pos_ff + n_units;
   // right half of the ancestor block at this level
   assign pos_plus_m = (pos_ff & ~(m_units - (UB+1)'(1))) | m_units;
   assign need       = EW'(bha_pkg::MIN_BLOCK) << lg_ff;
   assign m_bytes    = EW'(bha_pkg::MIN_BLOCK) << lgm_ff;
   assign off        = addr_ff - heap_base;
   assign units      = c_ff[EW-1:bha_pkg::MIN_SHIFT];
   assign bud_left   = ({2'b0, idx_ff} & units) == '0;
   assign bud_sum    = bud_left ? ({3'b0, idx_ff} + {1'b0, units})
                                : ({3'b0, idx_ff} - {1'b0, units});
   assign hi_idx     = (bud_ff > idx_ff) ? bud_ff : idx_ff;
   assign lo_idx     = (bud_ff > idx_ff) ? idx_ff : bud_ff;

   always_comb begin
      stat.is_free   = cmd_ff == bha_pkg::CMD_FREE;
      stat.size_bad  = (size_ff < 16'(bha_pkg::MIN_BLOCK))
                       || (size_ff > 16'(bha_pkg::MAX_BLOCK));
      stat.addr_bad  = (addr_ff < heap_base)
                       || (off[31:UB+bha_pkg::MIN_SHIFT] != '0);
      stat.hit       = !rdata[0] && (rdata >= need);
      stat.scan_last = pos_next[UB];
      stat.unw_done  = lgm_ff == LW'(UB);
      stat.go_left   = (pos_ff & m_units) == '0;
      stat.rd_free   = !rdata[0];
      stat.head_zero = rdata[EW-1:bha_pkg::MIN_SHIFT] == '0;
      stat.bud_out   = bud_left && (bud_sum[UB+2:UB] != '0);
      stat.bud_match = rdata == c_ff;
      stat.clr_done  = clr_ff == UB'(bha_pkg::UNITS - 1);
   end

   // table port selection
   always_comb begin
      rd_en   = cmd.scan_rd | cmd.unw_rd | cmd.fr_rd | cmd.bud_rd;
      rd_addr = idx_ff;
      if (cmd.scan_rd) begin
         rd_addr = pos_ff[UB-1:0];
      end else if (cmd.unw_rd) begin
         rd_addr = pos_plus_m[UB-1:0];
      end else if (cmd.bud_rd) begin
         rd_addr = bud_sum[UB-1:0];
      end
      wr_en   = cmd.clr_wr | cmd.scan_hit_wr | cmd.unw_wr | cmd.fr_head_wr
                | cmd.mrg_wr_hi | cmd.mrg_wr_lo;
      wr_addr = idx_ff;
      wr_data = '0;
      if (cmd.clr_wr) begin
         wr_addr = clr_ff;
         wr_data = (clr_ff == '0) ? EW'(bha_pkg::UNITS * bha_pkg::MIN_BLOCK) : '0;
      end else if (cmd.scan_hit_wr) begin
         wr_addr = pos_ff[UB-1:0];
         wr_data = need | EW'(1);
      end else if (cmd.unw_wr) begin
         wr_addr = pos_plus_m[UB-1:0];
         wr_data = m_bytes;
      end else if (cmd.fr_head_wr) begin
         wr_data = {rdata[EW-1:1], 1'b0};
      end else if (cmd.mrg_wr_hi) begin
         wr_addr = hi_idx;
      end else if (cmd.mrg_wr_lo) begin
         wr_addr = lo_idx;
         wr_data = {c_ff[EW-2:0], 1'b0};
      end
   end

   always_comb begin
      lg_in  = cmd.load ? lg_req : lg_ff;
      lgm_in = lgm_ff;
      if (cmd.scan_hit_wr) begin
         lgm_in = lg_ff;
      end else if (cmd.unw_next) begin
         lgm_in = lgm_ff + LW'(1);
      end
      pos_in = pos_ff;
      if (cmd.init_scan) begin
         pos_in = '0;
      end else if (cmd.scan_next) begin
         pos_in = pos_next;
      end
      idx_in = idx_ff;
      if (cmd.init_free) begin
         idx_in = off[UB+bha_pkg::MIN_SHIFT-1:bha_pkg::MIN_SHIFT];
      end else if (cmd.mrg_wr_lo) begin
         idx_in = lo_idx;
      end
      c_in = c_ff;
      if (cmd.fr_head_wr) begin
         c_in = {rdata[EW-1:1], 1'b0};
      end else if (cmd.mrg_wr_lo) begin
         c_in = {c_ff[EW-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clr_wr) begin
         clr_ff <= clr_ff + UB'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff  <= req_cmd;
         size_ff <= req_size;
         addr_ff <= req_block_addr;
      end
      if (cmd.bud_rd) begin
         bud_ff <= bud_sum[UB-1:0];
      end
      lg_ff  <= lg_in;
      lgm_ff <= lgm_in;
      pos_ff <= pos_in;
      idx_ff <= idx_in;
      c_ff   <= c_in;
      if (cmd.rsp_alloc) begin
         ok_ff  <= 1'b1;
         res_ff <= heap_base + 32'({pos_ff[UB-1:0], {bha_pkg::MIN_SHIFT{1'b0}}});
      end else if (cmd.rsp_free) begin
         ok_ff  <= 1'b1;
         res_ff <= addr_ff;
      end else if (cmd.rsp_fail) begin
         ok_ff  <= 1'b0;
         res_ff <= '0;
      end
   end

   assign rsp_ok          = ok_ff;
   assign rsp_result_addr = res_ff;

   bha_ram #(
      .WIDTH (EW),
      .DEPTH (bha_pkg::UNITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rdata)
   );

endmodule

/* rtl/bha_ctrl.sv */
// Controller: sequences table clear, allocate scan/unwind and free/merge walks.
// Depends on bha_pkg.
module bha_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output bha_pkg::dp_cmd_type  cmd,
   input  bha_pkg::dp_stat_type stat
);

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_CHK   = 4'd2;
   localparam logic [3:0] S_A_RD  = 4'd3;
   localparam logic [3:0] S_A_EV  = 4'd4;
   localparam logic [3:0] S_U_CHK = 4'd5;
   localparam logic [3:0] S_U_EV  = 4'd6;
   localparam logic [3:0] S_F_RD  = 4'd7;
   localparam logic [3:0] S_F_EV  = 4'd8;
   localparam logic [3:0] S_F_BUD = 4'd9;
   localparam logic [3:0] S_F_CMP = 4'd10;
   localparam logic [3:0] S_F_W2  = 4'd11;
   localparam logic [3:0] S_RESP  = 4'd12;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_CLR: begin
            cmd.clr_wr = 1'b1;
            if (stat.clr_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_CHK;
            end
         end
         S_CHK: begin
            if (stat.is_free) begin
               if (stat.addr_bad) begin
                  cmd.rsp_fail = 1'b1;
                  state_in     = S_RESP;
               end else begin
                  cmd.init_free = 1'b1;
                  state_in      = S_F_RD;
               end
            end else if (stat.size_bad) begin
               cmd.rsp_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.init_scan = 1'b1;
               state_in      = S_A_RD;
            end
         end
         S_A_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_A_EV;
         end
         S_A_EV: begin
            if (stat.hit) begin
               cmd.scan_hit_wr = 1'b1;
               state_in        = S_U_CHK;
            end else if (stat.scan_last) begin
               cmd.rsp_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_A_RD;
            end
         end
         // walk back up: a left-path ancestor re-marks its right half
         S_U_CHK: begin
            if (stat.unw_done) begin
               cmd.rsp_alloc = 1'b1;
               state_in      = S_RESP;
            end else if (stat.go_left) begin
               cmd.unw_rd = 1'b1;
               state_in   = S_U_EV;
            end else begin
               cmd.unw_next = 1'b1;
            end
         end
         S_U_EV: begin
            cmd.unw_wr   = stat.rd_free;
            cmd.unw_next = 1'b1;
            state_in     = S_U_CHK;
         end
         S_F_RD: begin
            cmd.fr_rd = 1'b1;
            state_in  = S_F_EV;
         end
         S_F_EV: begin
            if (stat.head_zero) begin
               cmd.rsp_fail = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.fr_head_wr = 1'b1;
               state_in       = S_F_BUD;
            end
         end
         S_F_BUD: begin
            if (stat.bud_out) begin
               cmd.rsp_free = 1'b1;
               state_in     = S_RESP;
            end else begin
               cmd.bud_rd = 1'b1;
               state_in   = S_F_CMP;
            end
         end
         S_F_CMP: begin
            if (stat.bud_match) begin
               cmd.mrg_wr_hi = 1'b1;
               state_in      = S_F_W2;
            end else begin
               cmd.rsp_free = 1'b1;
               state_in     = S_RESP;
            end
         end
         S_F_W2: begin
            cmd.mrg_wr_lo = 1'b1;
            state_in      = S_F_BUD;
         end
         S_RESP: begin
            if (rsp_ready) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

endmodule

/* rtl/bha_checker.sv */
// Port-level checks for the buddy allocator, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module bha_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_ok,
   input logic [31:0] rsp_result_addr,
   input logic        csr_pready
);

   `BHA_ASSERT(a_fail_zero, clock, reset, rsp_valid && !rsp_ok |-> rsp_result_addr == 32'd0, "failed request returned nonzero address")
   `BHA_NEVER(a_one_at_a_time, clock, reset, req_ready && rsp_valid, "new request taken while result pending")
   `BHA_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "ready stayed high after a request")
   `BHA_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_addr), "stalled result changed")
   `BHA_NEVER(a_pready, clock, reset, !csr_pready, "pready dropped")

endmodule

bind buddy_heap_allocator_core bha_checker u_bha_checker (.*);
